// File: src/orthonormal_basis_builder_core_assert.svh
// Assertion macros for the basis builder; they use the including module's clk and arst_n
`ifndef ORTHONORMAL_BASIS_BUILDER_CORE_ASSERT_SVH
`define ORTHONORMAL_BASIS_BUILDER_CORE_ASSERT_SVH

// check that ante implies cons at the same edge
`define OBB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("basis builder: implication check failed");

// check that cond never holds
`define OBB_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("basis builder: forbidden condition seen");

`endif

// File: src/obb_pkg.sv
// Shared types and constants for the orthonormal basis builder
package obb_pkg;

	localparam int IN_W     = 16;
	localparam int OUT_W    = 16;
	localparam int FUNC_W   = 4;
	localparam int THR_W    = 29;
	localparam int THR_FRAC = 28;

	localparam logic [THR_W-1:0] THR_RESET = 29'd268435;

	localparam logic [FUNC_W-1:0] MODE_U  = 4'd0;
	localparam logic [FUNC_W-1:0] MODE_V  = 4'd1;
	localparam logic [FUNC_W-1:0] MODE_W  = 4'd2;
	localparam logic [FUNC_W-1:0] MODE_UV = 4'd3;
	localparam logic [FUNC_W-1:0] MODE_VU = 4'd4;
	localparam logic [FUNC_W-1:0] MODE_UW = 4'd5;
	localparam logic [FUNC_W-1:0] MODE_WU = 4'd6;
	localparam logic [FUNC_W-1:0] MODE_VW = 4'd7;
	localparam logic [FUNC_W-1:0] MODE_WV = 4'd8;

	typedef struct packed {
		logic [FUNC_W-1:0]      func;
		logic signed [IN_W-1:0] first_x;
		logic signed [IN_W-1:0] first_y;
		logic signed [IN_W-1:0] first_z;
		logic signed [IN_W-1:0] second_x;
		logic signed [IN_W-1:0] second_y;
		logic signed [IN_W-1:0] second_z;
	} cmd_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] u_x;
		logic signed [OUT_W-1:0] u_y;
		logic signed [OUT_W-1:0] u_z;
		logic signed [OUT_W-1:0] v_x;
		logic signed [OUT_W-1:0] v_y;
		logic signed [OUT_W-1:0] v_z;
		logic signed [OUT_W-1:0] w_x;
		logic signed [OUT_W-1:0] w_y;
		logic signed [OUT_W-1:0] w_z;
		logic                    degenerate;
	} res_t;

endpackage

// File: src/obb_norm.sv
// Pipelined vector normaliser: squares, length, bit-per-stage divide, bit-per-stage root
module obb_norm #(
	parameter int IW = 16,
	parameter int FRAC = 14,
	parameter int PW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_v,
	input  logic [2:0][IW-1:0]   in_c,
	input  logic [PW-1:0]        in_pl,
	output logic                 out_v,
	output logic [2:0][FRAC+1:0] out_c,
	output logic                 out_zero,
	output logic [PW-1:0]        out_pl
);
	localparam int XW = 2 * IW;
	localparam int LW = XW + 2;
	localparam int QW = 2 * FRAC + 1;
	localparam int DS = 2 * FRAC + 1;
	localparam int RW = FRAC + 1;
	localparam int MW = FRAC + 2;
	localparam int SS = FRAC + 1;

	logic [2:0][IW-1:0] mag;
	logic [LW-1:0]      len_sum;

	logic               v_s1;
	logic [2:0][XW-1:0] x2_s1;
	logic [2:0]         neg_s1;
	logic [PW-1:0]      pl_s1;

	logic               v_s2;
	logic [LW-1:0]      len_s2;
	logic [2:0][XW-1:0] x2_s2;
	logic [2:0]         neg_s2;
	logic               zero_s2;
	logic [PW-1:0]      pl_s2;

	logic               dv    [DS];
	logic [LW-1:0]      dlen  [DS];
	logic [2:0][LW-1:0] drem  [DS];
	logic [2:0][QW-1:0] dq    [DS];
	logic [2:0]         dneg  [DS];
	logic               dzero [DS];
	logic [PW-1:0]      dpl   [DS];

	logic               sv    [SS];
	logic [2:0][MW-1:0] srem  [SS];
	logic [2:0][RW-1:0] sroot [SS];
	logic [2:0][QW-1:0] sq    [SS];
	logic [2:0]         sneg  [SS];
	logic               szero [SS];
	logic [PW-1:0]      spl   [SS];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = in_c[i][IW-1] ? IW'(-in_c[i]) : in_c[i];
		end
		len_sum = LW'(x2_s1[0]) + LW'(x2_s1[1]) + LW'(x2_s1[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			x2_s1[i]  <= XW'(mag[i]) * XW'(mag[i]);
			neg_s1[i] <= in_c[i][IW-1];
		end
		pl_s1   <= in_pl;
		len_s2  <= len_sum;
		zero_s2 <= (len_sum == '0);
		x2_s2   <= x2_s1;
		neg_s2  <= neg_s1;
		pl_s2   <= pl_s1;
	end

	for (genvar d = 0; d < DS; d++) begin : g_div
		logic               p_v;
		logic [LW-1:0]      p_len;
		logic [2:0]         p_neg;
		logic               p_zero;
		logic [PW-1:0]      p_pl;
		logic [2:0][LW-1:0] rem_nx;
		logic [2:0][QW-1:0] q_nx;

		if (d == 0) begin : g_first
			assign p_v    = v_s2;
			assign p_len  = len_s2;
			assign p_neg  = neg_s2;
			assign p_zero = zero_s2;
			assign p_pl   = pl_s2;
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					if (LW'(x2_s2[i]) >= len_s2) begin
						rem_nx[i] = LW'(x2_s2[i]) - len_s2;
						q_nx[i]   = QW'(1);
					end else begin
						rem_nx[i] = LW'(x2_s2[i]);
						q_nx[i]   = '0;
					end
				end
			end
		end else begin : g_step
			logic [2:0][LW:0] rem2;
			assign p_v    = dv[d-1];
			assign p_len  = dlen[d-1];
			assign p_neg  = dneg[d-1];
			assign p_zero = dzero[d-1];
			assign p_pl   = dpl[d-1];
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem2[i] = {drem[d-1][i], 1'b0};
					if (rem2[i] >= {1'b0, dlen[d-1]}) begin
						rem_nx[i] = LW'(rem2[i] - {1'b0, dlen[d-1]});
						q_nx[i]   = {dq[d-1][i][QW-2:0], 1'b1};
					end else begin
						rem_nx[i] = LW'(rem2[i]);
						q_nx[i]   = {dq[d-1][i][QW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[d] <= 1'b0;
			end else begin
				dv[d] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			dlen[d]  <= p_len;
			drem[d]  <= rem_nx;
			dq[d]    <= q_nx;
			dneg[d]  <= p_neg;
			dzero[d] <= p_zero;
			dpl[d]   <= p_pl;
		end
	end

	for (genvar j = 0; j < SS; j++) begin : g_root
		logic                 p_v;
		logic [2:0][MW-1:0]   p_rem;
		logic [2:0][RW-1:0]   p_root;
		logic [2:0][QW-1:0]   p_q;
		logic [2:0]           p_neg;
		logic                 p_zero;
		logic [PW-1:0]        p_pl;
		logic [2:0][QW:0]     qp;
		logic [2:0][MW+1:0]   pre;
		logic [2:0][MW+1:0]   trial;
		logic [2:0][MW-1:0]   rem_nx;
		logic [2:0][RW-1:0]   root_nx;

		if (j == 0) begin : g_first
			assign p_v    = dv[DS-1];
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_q    = dq[DS-1];
			assign p_neg  = dneg[DS-1];
			assign p_zero = dzero[DS-1];
			assign p_pl   = dpl[DS-1];
		end else begin : g_step
			assign p_v    = sv[j-1];
			assign p_rem  = srem[j-1];
			assign p_root = sroot[j-1];
			assign p_q    = sq[j-1];
			assign p_neg  = sneg[j-1];
			assign p_zero = szero[j-1];
			assign p_pl   = spl[j-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				qp[i]    = {1'b0, p_q[i]};
				pre[i]   = {p_rem[i], qp[i][2*(FRAC-j) +: 2]};
				trial[i] = (MW+2)'({p_root[i], 2'b01});
				if (pre[i] >= trial[i]) begin
					rem_nx[i]  = MW'(pre[i] - trial[i]);
					root_nx[i] = {p_root[i][RW-2:0], 1'b1};
				end else begin
					rem_nx[i]  = MW'(pre[i]);
					root_nx[i] = {p_root[i][RW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv[j] <= 1'b0;
			end else begin
				sv[j] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			srem[j]  <= rem_nx;
			sroot[j] <= root_nx;
			sq[j]    <= p_q;
			sneg[j]  <= p_neg;
			szero[j] <= p_zero;
			spl[j]   <= p_pl;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sneg[SS-1][i]) begin
				out_c[i] = MW'(-{1'b0, sroot[SS-1][i]});
			end else begin
				out_c[i] = {1'b0, sroot[SS-1][i]};
			end
		end
	end

	assign out_v    = sv[SS-1];
	assign out_zero = szero[SS-1];
	assign out_pl   = spl[SS-1];

endmodule

// File: src/obb_helper.sv
// Helper-axis stage: pair cross product or x/y fallback axis with threshold test
module obb_helper #(
	parameter int FRAC = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_v,
	input  logic [obb_pkg::FUNC_W-1:0]    func,
	input  logic                          pair,
	input  logic [2:0][FRAC+1:0]          a,
	input  logic [2:0][FRAC+1:0]          b,
	input  logic                          za,
	input  logic                          zb,
	input  logic [obb_pkg::THR_W-1:0]     thr,
	output logic                          out_v,
	output logic [2:0][FRAC+2:0]          out_t,
	output logic [obb_pkg::FUNC_W-1:0]    out_func,
	output logic                          out_ok,
	output logic [2:0][FRAC+1:0]          out_a
);
	localparam int NW  = FRAC + 2;
	localparam int TW  = FRAC + 3;
	localparam int PRW = 2 * NW;
	localparam int DW  = PRW + 1;
	localparam int SLW = PRW + 1;
	localparam int SH  = 2 * FRAC - obb_pkg::THR_FRAC;
	localparam int LSH = (SH < 0) ? -SH : 0;
	localparam int TSH = (SH > 0) ? SH : 0;
	localparam int CW  = 2 * FRAC + obb_pkg::THR_W + 16;

	logic signed [PRW-1:0] ax [3];
	logic signed [PRW-1:0] bx [3];
	logic                  ok_in;
	logic                  swap_in;

	logic                       v_s1;
	logic signed [PRW-1:0]      p_s1 [6];
	logic signed [PRW-1:0]      sq_s1 [2];
	logic                       swap_s1;
	logic                       pair_s1;
	logic                       ok_s1;
	logic [obb_pkg::FUNC_W-1:0] func_s1;
	logic [2:0][NW-1:0]         a_s1;

	logic signed [DW-1:0] d    [3];
	logic signed [DW-1:0] rnd  [3];
	logic [2:0][TW-1:0]   t_pair;
	logic [2:0][TW-1:0]   t_single;
	logic [SLW-1:0]       hlen;
	logic                 below;

	logic                       v_s2;
	logic [2:0][TW-1:0]         t_s2;
	logic [obb_pkg::FUNC_W-1:0] func_s2;
	logic                       ok_s2;
	logic [2:0][NW-1:0]         a_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax[i] = PRW'($signed(a[i]));
			bx[i] = PRW'($signed(b[i]));
		end
		ok_in   = (func <= obb_pkg::MODE_WV) && !za && (!pair || !zb);
		swap_in = func inside {obb_pkg::MODE_VU, obb_pkg::MODE_UW, obb_pkg::MODE_WV};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0]  <= ax[1] * bx[2];
		p_s1[1]  <= ax[2] * bx[1];
		p_s1[2]  <= ax[2] * bx[0];
		p_s1[3]  <= ax[0] * bx[2];
		p_s1[4]  <= ax[0] * bx[1];
		p_s1[5]  <= ax[1] * bx[0];
		sq_s1[0] <= ax[1] * ax[1];
		sq_s1[1] <= ax[2] * ax[2];
		swap_s1  <= swap_in;
		pair_s1  <= pair;
		ok_s1    <= ok_in;
		func_s1  <= func;
		a_s1     <= a;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i] = DW'(p_s1[2*i]) - DW'(p_s1[2*i+1]);
			if (swap_s1) begin
				d[i] = -d[i];
			end
			rnd[i]    = d[i] + (DW'(1) <<< (FRAC - 1));
			t_pair[i] = TW'(rnd[i] >>> FRAC);
		end
		hlen  = SLW'(unsigned'(sq_s1[0])) + SLW'(unsigned'(sq_s1[1]));
		below = ((CW'(hlen) << LSH) < (CW'(thr) << TSH));
		if (below) begin
			t_single[0] = TW'(-TW'($signed(a_s1[2])));
			t_single[1] = '0;
			t_single[2] = TW'($signed(a_s1[0]));
		end else begin
			t_single[0] = '0;
			t_single[1] = TW'($signed(a_s1[2]));
			t_single[2] = TW'(-TW'($signed(a_s1[1])));
		end
	end

	always_ff @(posedge clk) begin
		t_s2    <= pair_s1 ? t_pair : t_single;
		func_s2 <= func_s1;
		ok_s2   <= ok_s1;
		a_s2    <= a_s1;
	end

	assign out_v    = v_s2;
	assign out_t    = t_s2;
	assign out_func = func_s2;
	assign out_ok   = ok_s2;
	assign out_a    = a_s2;

endmodule

// File: src/obb_final.sv
// Completion stage: last cross product, axis placement by mode, result register
module obb_final #(
	parameter int FRAC = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_v,
	input  logic [obb_pkg::FUNC_W-1:0] func,
	input  logic                       ok,
	input  logic                       zc,
	input  logic [2:0][FRAC+1:0]       a,
	input  logic [2:0][FRAC+1:0]       c,
	output logic                       done,
	output obb_pkg::res_t              res
);
	localparam int NW  = FRAC + 2;
	localparam int PRW = 2 * NW;
	localparam int DW  = PRW + 1;
	localparam int OW  = obb_pkg::OUT_W;

	logic signed [PRW-1:0] ax [3];
	logic signed [PRW-1:0] cx [3];

	logic                       v_s1;
	logic signed [PRW-1:0]      p_s1 [6];
	logic                       swap_s1;
	logic                       ok_s1;
	logic [obb_pkg::FUNC_W-1:0] func_s1;
	logic [2:0][NW-1:0]         a_s1;
	logic [2:0][NW-1:0]         c_s1;

	logic signed [DW-1:0]  d   [3];
	logic signed [DW-1:0]  rnd [3];
	logic [2:0][OW-1:0]    xo;
	logic [2:0][OW-1:0]    ao;
	logic [2:0][OW-1:0]    co;
	logic [2:0][OW-1:0]    uo;
	logic [2:0][OW-1:0]    vo;
	logic [2:0][OW-1:0]    wo;
	obb_pkg::res_t         res_nx;

	logic          done_s2;
	obb_pkg::res_t res_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax[i] = PRW'($signed(a[i]));
			cx[i] = PRW'($signed(c[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			v_s1    <= in_v;
			done_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= ax[1] * cx[2];
		p_s1[1] <= ax[2] * cx[1];
		p_s1[2] <= ax[2] * cx[0];
		p_s1[3] <= ax[0] * cx[2];
		p_s1[4] <= ax[0] * cx[1];
		p_s1[5] <= ax[1] * cx[0];
		swap_s1 <= func inside {obb_pkg::MODE_V, obb_pkg::MODE_UV, obb_pkg::MODE_WU,
			obb_pkg::MODE_VW};
		ok_s1   <= ok && !zc;
		func_s1 <= func;
		a_s1    <= a;
		c_s1    <= c;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i] = DW'(p_s1[2*i]) - DW'(p_s1[2*i+1]);
			if (swap_s1) begin
				d[i] = -d[i];
			end
			rnd[i] = d[i] + (DW'(1) <<< (FRAC - 1));
			xo[i]  = OW'(rnd[i] >>> FRAC);
			ao[i]  = OW'($signed(a_s1[i]));
			co[i]  = OW'($signed(c_s1[i]));
		end
		case (func_s1)
			obb_pkg::MODE_U, obb_pkg::MODE_UW: begin
				uo = ao; vo = co; wo = xo;
			end
			obb_pkg::MODE_V, obb_pkg::MODE_VW: begin
				uo = co; vo = ao; wo = xo;
			end
			obb_pkg::MODE_W, obb_pkg::MODE_WV: begin
				uo = co; vo = xo; wo = ao;
			end
			obb_pkg::MODE_UV: begin
				uo = ao; vo = xo; wo = co;
			end
			obb_pkg::MODE_VU: begin
				uo = xo; vo = ao; wo = co;
			end
			obb_pkg::MODE_WU: begin
				uo = xo; vo = co; wo = ao;
			end
			default: begin
				uo = '0; vo = '0; wo = '0;
			end
		endcase
		if (!ok_s1) begin
			uo = '0; vo = '0; wo = '0;
		end
		res_nx.u_x        = uo[0];
		res_nx.u_y        = uo[1];
		res_nx.u_z        = uo[2];
		res_nx.v_x        = vo[0];
		res_nx.v_y        = vo[1];
		res_nx.v_z        = vo[2];
		res_nx.w_x        = wo[0];
		res_nx.w_y        = wo[1];
		res_nx.w_z        = wo[2];
		res_nx.degenerate = !ok_s1;
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_nx;
	end

	assign done = done_s2;
	assign res  = res_s2;

endmodule

// File: src/orthonormal_basis_builder_core.sv
// Top level of the orthonormal basis builder: config register and pipeline wiring
//
//  channel   | signals                | direction | transaction
//  ----------+------------------------+-----------+------------------------------
//  command   | start, busy, cmd       | in; busy: out | start high, busy low
//  result    | done, res              | out       | done high for one cycle
//  config    | cfg_we, cfg_wdata      | in        | cfg_we high
//
//  One command per clock; busy is never raised.
//  Pipeline depth is set mostly by the two chained normalisers,
//  each resolving one quotient bit and then one root bit per stage.
//  Reset clears valid bits and loads the threshold with its default.
//  Results cannot be stalled; each is replaced in the output register in the next cycle.
module orthonormal_basis_builder_core #(
	parameter int FRAC_BITS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  obb_pkg::cmd_t               cmd,
	output logic                        busy,
	output logic                        done,
	output obb_pkg::res_t               res,
	input  logic                        cfg_we,
	input  logic [obb_pkg::THR_W-1:0]   cfg_wdata
);
	`include "orthonormal_basis_builder_core_assert.svh"

	localparam int NW = FRAC_BITS + 2;
	localparam int TW = FRAC_BITS + 3;
	localparam int FW = obb_pkg::FUNC_W;
	localparam int HPW = FW + 1 + 3 * NW;

	logic [obb_pkg::THR_W-1:0] thr_q;
	logic                      in_v;
	logic                      pair_in;

	logic               fa_v;
	logic [2:0][NW-1:0] fa_c;
	logic               fa_zero;
	logic [FW-1:0]      fa_func;
	logic               fb_v;
	logic [2:0][NW-1:0] fb_c;
	logic               fb_zero;
	logic               fb_pair;

	logic               h_v;
	logic [2:0][TW-1:0] h_t;
	logic [FW-1:0]      h_func;
	logic               h_ok;
	logic [2:0][NW-1:0] h_a;

	logic               n_v;
	logic [2:0][NW-1:0] n_c;
	logic               n_zero;
	logic [HPW-1:0]     n_pl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= obb_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign busy    = 1'b0;
	assign in_v    = start && !busy;
	assign pair_in = cmd.func inside {[obb_pkg::MODE_UV : obb_pkg::MODE_WV]};

	obb_norm #(.IW(obb_pkg::IN_W), .FRAC(FRAC_BITS), .PW(FW)) u_norm_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (in_v),
		.in_c     ({cmd.first_z, cmd.first_y, cmd.first_x}),
		.in_pl    (cmd.func),
		.out_v    (fa_v),
		.out_c    (fa_c),
		.out_zero (fa_zero),
		.out_pl   (fa_func)
	);

	obb_norm #(.IW(obb_pkg::IN_W), .FRAC(FRAC_BITS), .PW(1)) u_norm_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (in_v),
		.in_c     ({cmd.second_z, cmd.second_y, cmd.second_x}),
		.in_pl    (pair_in),
		.out_v    (fb_v),
		.out_c    (fb_c),
		.out_zero (fb_zero),
		.out_pl   (fb_pair)
	);

	obb_helper #(.FRAC(FRAC_BITS)) u_helper (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (fa_v && fb_v),
		.func     (fa_func),
		.pair     (fb_pair),
		.a        (fa_c),
		.b        (fb_c),
		.za       (fa_zero),
		.zb       (fb_zero),
		.thr      (thr_q),
		.out_v    (h_v),
		.out_t    (h_t),
		.out_func (h_func),
		.out_ok   (h_ok),
		.out_a    (h_a)
	);

	obb_norm #(.IW(TW), .FRAC(FRAC_BITS), .PW(HPW)) u_norm_helper (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (h_v),
		.in_c     (h_t),
		.in_pl    ({h_func, h_ok, h_a}),
		.out_v    (n_v),
		.out_c    (n_c),
		.out_zero (n_zero),
		.out_pl   (n_pl)
	);

	obb_final #(.FRAC(FRAC_BITS)) u_final (
		.clk    (clk),
		.arst_n (arst_n),
		.in_v   (n_v),
		.func   (n_pl[HPW-1 -: FW]),
		.ok     (n_pl[3*NW]),
		.zc     (n_zero),
		.a      (n_pl[3*NW-1:0]),
		.c      (n_c),
		.done   (done),
		.res    (res)
	);

	`OBB_ASSERT_IMPL(a_degenerate_zero, done && res.degenerate,
		(res.u_x | res.u_y | res.u_z | res.v_x | res.v_y | res.v_z |
		res.w_x | res.w_y | res.w_z) == '0)
	`OBB_ASSERT_NEVER(a_two_zero_axes, done && !res.degenerate &&
		(((res.u_x | res.u_y | res.u_z) == '0 && (res.v_x | res.v_y | res.v_z) == '0) ||
		((res.v_x | res.v_y | res.v_z) == '0 && (res.w_x | res.w_y | res.w_z) == '0) ||
		((res.u_x | res.u_y | res.u_z) == '0 && (res.w_x | res.w_y | res.w_z) == '0)))
	`OBB_ASSERT_IMPL(a_thr_reset, $rose(arst_n), thr_q == obb_pkg::THR_RESET)

endmodule
